>>> hdl/srp_pkg.sv
// Shared constants, types and helper functions of the shadow record parser.
// Depends on nothing; every other file of the block but srp_ram refers to it by scoped names.

package srp_pkg;

    // Sizing of the parser and its record table.
    localparam int MAX_ENTRIES   = 16;
    localparam int NAME_CAPACITY = 32;
    localparam int HEX_DIGITS    = 64;
    localparam int HASH_WORDS    = 4;

    // Records waiting between the parser and the emitter, and output queue depth.
    localparam int REC_SLOTS = 2;
    localparam int OUT_DEPTH = 4;

    // Derived widths.
    localparam int NAME_CW     = $clog2(NAME_CAPACITY);
    localparam int HEX_CW      = $clog2(HEX_DIGITS + 2);
    localparam int REC_CW      = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_AW     = $clog2(REC_SLOTS);
    localparam int SLOT_CW     = $clog2(REC_SLOTS + 1);
    localparam int WORD_AW     = $clog2(HASH_WORDS);
    localparam int NAME_RAM_AW = SLOT_AW + NAME_CW;
    localparam int NAME_RAM_DEPTH = 1 << NAME_RAM_AW;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    // Result field widths.
    localparam int ENTRY_W    = 4;
    localparam int PART_IDX_W = 5;
    localparam int DATA_W     = 64;
    localparam int NAME_LEN_W = 5;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_COMMENT = 8'h23;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    // Part kinds.
    localparam logic PART_NAME = 1'b0;
    localparam logic PART_HASH = 1'b1;

    // One finished record waiting to be emitted.
    typedef struct packed {
        logic [ENTRY_W-1:0] entry_slot;
        logic [NAME_CW-1:0] name_count;
    } t_desc;

    // Writes from the parser into the name memory and the record queue.
    typedef struct packed {
        logic               name_we;
        logic [NAME_CW-1:0] name_pos;
        logic [7:0]         name_byte;
        logic               hash_we;
        logic [WORD_AW-1:0] hash_word;
        logic [7:0]         hash_byte;
        logic               push;
        t_desc              desc;
    } t_front_wr;

    // One result beat.
    typedef struct packed {
        logic [ENTRY_W-1:0]    entry_slot;
        logic                  part_kind;
        logic [PART_IDX_W-1:0] part_index;
        logic [DATA_W-1:0]     part_data;
        logic [NAME_LEN_W-1:0] name_length;
        logic                  last_part;
    } t_part;

    // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

>>> hdl/srp_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; used for the name store of the shadow record parser.

module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/srp_front.sv
// Front end of the shadow record parser: classifies each byte and tracks the line.
// Depends on srp_pkg; drives name memory writes, hash writes and record pushes.

module srp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_end_of_file,
    output srp_pkg::t_front_wr    o_wr
);

    typedef enum logic [2:0] {
        PH_START,
        PH_NAME,
        PH_HASH,
        PH_SKIP,
        PH_FULL
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [srp_pkg::NAME_CW-1:0]  r_name_count, n_name_count;
    logic                         r_too_long, n_too_long;
    logic [srp_pkg::HEX_CW-1:0]   r_hex, n_hex;
    logic [3:0]                   r_high, n_high;
    logic                         r_bad, n_bad;
    logic [srp_pkg::REC_CW-1:0]   r_rec, n_rec;

    logic                         term;
    logic [4:0]                   digit;
    logic [3:0]                   dval;
    logic [srp_pkg::NAME_CW-1:0]  base_cnt;
    srp_pkg::t_front_wr           wr;

    assign term  = (i_byte_value == srp_pkg::CH_LF) || (i_byte_value == srp_pkg::CH_CR);
    assign digit = srp_pkg::digit_value(i_byte_value);
    assign dval  = digit[4] ? digit[3:0] : 4'd0;
    // A new line starts its name from zero.
    assign base_cnt = (r_phase == PH_START) ? '0 : r_name_count;

    // Next-state logic for one accepted byte, then the line close.
    always_comb begin
        n_phase      = r_phase;
        n_name_count = r_name_count;
        n_too_long   = r_too_long;
        n_hex        = r_hex;
        n_high       = r_high;
        n_bad        = r_bad;
        n_rec        = r_rec;
        wr           = '0;
        wr.name_pos  = base_cnt;
        wr.name_byte = i_byte_value;
        wr.hash_word = r_hex[5:4];
        wr.hash_byte = {r_high, dval};

        if (i_accept && r_phase != PH_FULL) begin
            if (!term) begin
                case (r_phase)
                    PH_START, PH_NAME: begin
                        if (r_phase == PH_START) begin
                            n_name_count = '0;
                            n_too_long   = 1'b0;
                        end
                        if (r_phase == PH_START && i_byte_value == srp_pkg::CH_COMMENT) begin
                            n_phase = PH_SKIP;
                        end else if (i_byte_value == srp_pkg::CH_COLON) begin
                            n_phase = PH_HASH;
                            n_hex   = '0;
                            n_high  = 4'd0;
                            n_bad   = 1'b0;
                        end else begin
                            n_phase = PH_NAME;
                            if (base_cnt < srp_pkg::NAME_CW'(srp_pkg::NAME_CAPACITY - 1)) begin
                                wr.name_we   = 1'b1;
                                n_name_count = base_cnt + 1'b1;
                            end else begin
                                n_too_long = 1'b1;
                            end
                        end
                    end
                    PH_HASH: begin
                        if (r_hex >= srp_pkg::HEX_CW'(srp_pkg::HEX_DIGITS)) begin
                            n_hex = srp_pkg::HEX_CW'(srp_pkg::HEX_DIGITS + 1);
                        end else begin
                            if (!digit[4]) begin
                                n_bad = 1'b1;
                            end
                            if (!r_hex[0]) begin
                                n_high = dval;
                            end else begin
                                wr.hash_we = 1'b1;
                            end
                            n_hex = r_hex + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // A terminator or the end of file closes the line.
            if (term || i_end_of_file) begin
                if (n_phase == PH_HASH && n_name_count != '0 && !n_too_long &&
                    n_hex == srp_pkg::HEX_CW'(srp_pkg::HEX_DIGITS) && !n_bad) begin
                    wr.push            = 1'b1;
                    wr.desc.entry_slot = srp_pkg::ENTRY_W'(r_rec);
                    wr.desc.name_count = n_name_count;
                    n_rec              = r_rec + 1'b1;
                    if (n_rec >= srp_pkg::REC_CW'(srp_pkg::MAX_ENTRIES)) begin
                        n_phase = PH_FULL;
                    end else begin
                        n_phase = PH_START;
                    end
                end else begin
                    n_phase = PH_START;
                end
            end
        end

        // The end of file returns the parser to its reset state.
        if (i_accept && i_end_of_file) begin
            n_phase      = PH_START;
            n_name_count = '0;
            n_too_long   = 1'b0;
            n_hex        = '0;
            n_high       = 4'd0;
            n_bad        = 1'b0;
            n_rec        = '0;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_name_count <= '0;
            r_too_long   <= 1'b0;
            r_hex        <= '0;
            r_high       <= 4'd0;
            r_bad        <= 1'b0;
            r_rec        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_name_count <= n_name_count;
            r_too_long   <= n_too_long;
            r_hex        <= n_hex;
            r_high       <= n_high;
            r_bad        <= n_bad;
            r_rec        <= n_rec;
        end
    end

    assign o_wr = wr;

endmodule

>>> hdl/srp_rec_queue.sv
// Record queue of the shadow record parser: descriptors and hash words per slot.
// Depends on srp_pkg; written by srp_front, drained by srp_back.

module srp_rec_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srp_pkg::t_front_wr            i_wr,
    input  logic                          i_pop,
    input  logic [srp_pkg::WORD_AW-1:0]   i_hash_rd_word,
    output logic                          o_full,
    output logic                          o_empty,
    output logic [srp_pkg::SLOT_AW-1:0]   o_wslot,
    output logic [srp_pkg::SLOT_AW-1:0]   o_rslot,
    output srp_pkg::t_desc                o_head,
    output logic [srp_pkg::DATA_W-1:0]    o_hash_rd
);

    srp_pkg::t_desc                r_desc [srp_pkg::REC_SLOTS];
    logic [srp_pkg::DATA_W-1:0]    r_hash [srp_pkg::REC_SLOTS][srp_pkg::HASH_WORDS];
    logic [srp_pkg::SLOT_AW-1:0]   r_wptr, r_rptr;
    logic [srp_pkg::SLOT_CW-1:0]   r_count;

    // Descriptor and hash storage of the slot being filled.
    always_ff @(posedge i_clk) begin
        if (i_wr.hash_we) begin
            r_hash[r_wptr][i_wr.hash_word] <= {r_hash[r_wptr][i_wr.hash_word][55:0],
                                               i_wr.hash_byte};
        end
        if (i_wr.push) begin
            r_desc[r_wptr] <= i_wr.desc;
        end
    end

    // Slot pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + srp_pkg::SLOT_CW'(i_wr.push) - srp_pkg::SLOT_CW'(i_pop);
        end
    end

    assign o_full    = (r_count == srp_pkg::SLOT_CW'(srp_pkg::REC_SLOTS));
    assign o_empty   = (r_count == '0);
    assign o_wslot   = r_wptr;
    assign o_rslot   = r_rptr;
    assign o_head    = r_desc[r_rptr];
    assign o_hash_rd = r_hash[r_rptr][i_hash_rd_word];

endmodule

>>> hdl/srp_back.sv
// Back end of the shadow record parser: walks each queued record part by part.
// Depends on srp_pkg; reads the name memory and record queue, feeds the output queue.

module srp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  srp_pkg::t_desc                i_head,
    input  logic [srp_pkg::DATA_W-1:0]    i_hash_data,
    input  logic [7:0]                    i_name_data,
    input  logic                          i_pop,
    output logic                          o_desc_pop,
    output logic [srp_pkg::WORD_AW-1:0]   o_hash_word,
    output logic                          o_name_re,
    output logic [srp_pkg::NAME_CW-1:0]   o_name_pos,
    output srp_pkg::t_part                o_part,
    output logic                          o_empty
);

    logic                              r_in_hash;
    logic [srp_pkg::NAME_CW-1:0]       r_idx;
    logic                              r_s1_valid;
    srp_pkg::t_part                    r_s1;
    srp_pkg::t_part                    r_out [srp_pkg::OUT_DEPTH];
    logic [srp_pkg::OUT_AW-1:0]        r_wp, r_rp;
    logic [srp_pkg::OUT_CW-1:0]        r_out_count;

    logic                              issue;
    logic                              last_name;
    logic                              last_word;
    logic                              out_pop;
    logic [srp_pkg::OUT_CW:0]          occupancy;
    srp_pkg::t_part                    s1_part;
    srp_pkg::t_part                    s1_final;

    // Issue a part only when the output queue can take everything in flight.
    assign occupancy = {1'b0, r_out_count} + (srp_pkg::OUT_CW + 1)'(r_s1_valid);
    assign issue     = i_head_valid && (occupancy < (srp_pkg::OUT_CW + 1)'(srp_pkg::OUT_DEPTH));
    assign last_name = (r_idx == srp_pkg::NAME_CW'(i_head.name_count - 1'b1));
    assign last_word = (r_idx[srp_pkg::WORD_AW-1:0] == srp_pkg::WORD_AW'(srp_pkg::HASH_WORDS - 1));
    assign out_pop   = i_pop && (r_out_count != '0);

    assign o_hash_word = r_idx[srp_pkg::WORD_AW-1:0];
    assign o_name_re   = issue && !r_in_hash;
    assign o_name_pos  = r_idx;
    assign o_desc_pop  = issue && r_in_hash && last_word;

    // Part fields known at issue; the name byte comes from the registered memory read and joins r_s1.
    always_comb begin
        s1_part             = '0;
        s1_part.entry_slot  = i_head.entry_slot;
        s1_part.part_kind   = r_in_hash ? srp_pkg::PART_HASH : srp_pkg::PART_NAME;
        s1_part.part_index  = srp_pkg::PART_IDX_W'(r_idx);
        s1_part.part_data   = r_in_hash ? i_hash_data : '0;
        s1_part.name_length = srp_pkg::NAME_LEN_W'(i_head.name_count);
        s1_part.last_part   = r_in_hash && last_word;
    end

    always_comb begin
        s1_final = r_s1;
        if (r_s1.part_kind == srp_pkg::PART_NAME) begin
            s1_final.part_data = {{(srp_pkg::DATA_W - 8){1'b0}}, i_name_data};
        end
    end

    // Part sequencer and issue stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_hash  <= 1'b0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            if (issue) begin
                if (!r_in_hash) begin
                    if (last_name) begin
                        r_in_hash <= 1'b1;
                        r_idx     <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end else if (last_word) begin
                    r_in_hash <= 1'b0;
                    r_idx     <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= s1_part;
        end
    end

    // Output queue payload.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out[r_wp] <= s1_final;
        end
    end

    // Output queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (out_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_out_count <= r_out_count + srp_pkg::OUT_CW'(r_s1_valid)
                           - srp_pkg::OUT_CW'(out_pop);
        end
    end

    assign o_part  = r_out[r_rp];
    assign o_empty = (r_out_count == '0);

endmodule

>>> hdl/shadow_record_parser.sv
// Top level of the shadow record parser: front end, record queue, name memory, back end.
// Depends on srp_pkg, srp_ram, srp_front, srp_rec_queue and srp_back.
//
// Usage:
// Input channel: one file byte per beat on i_byte_value, with i_end_of_file set on
// the last byte of the file. A beat is taken when push is high and full is low.
// Output channel: one record part per beat. While empty is low the oldest part is
// on the o_ ports; it is taken when pop is high. Each accepted line gives its name
// bytes, then four hash words, the last marked by o_last_part.
// Throughput: one byte per cycle while full is low. full rises only while two finished
// records are still waiting in the record queue; parts drain at one per cycle while the
// output queue has room, and a valid line (at least 66 bytes) never outruns the emitter.
// With the emitter idle, a closed line passes the record queue, the issue register and the
// output queue before empty falls; later parts follow one per cycle while there is room.
// A stalled receiver fills the four-entry output queue, then the record queue,
// and finally raises full; nothing is dropped.
// Reset (synchronous, active low) empties both queues and starts a new file; the
// end-of-file byte does the same for the parser once its line is closed.

module shadow_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_entry_slot,
    output logic        o_part_kind,
    output logic [4:0]  o_part_index,
    output logic [63:0] o_part_data,
    output logic [4:0]  o_name_length,
    output logic        o_last_part
);

    srp_pkg::t_front_wr                  wr;
    srp_pkg::t_desc                      head;
    srp_pkg::t_part                      part;
    logic                                q_full, q_empty;
    logic [srp_pkg::SLOT_AW-1:0]         wslot, rslot;
    logic [srp_pkg::DATA_W-1:0]          hash_rd;
    logic [srp_pkg::WORD_AW-1:0]         hash_word;
    logic                                desc_pop;
    logic                                name_re;
    logic [srp_pkg::NAME_CW-1:0]         name_pos;
    logic [7:0]                          name_rd;
    logic                                accept;

    assign accept = push && !q_full;
    assign full   = q_full;

    // Byte classification and line tracking.
    srp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte_value  (i_byte_value),
        .i_end_of_file (i_end_of_file),
        .o_wr          (wr)
    );

    // Name bytes, one region per record slot.
    srp_ram #(
        .WIDTH (8),
        .DEPTH (srp_pkg::NAME_RAM_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (wr.name_we),
        .i_waddr ({wslot, wr.name_pos}),
        .i_wdata (wr.name_byte),
        .i_re    (name_re),
        .i_raddr ({rslot, name_pos}),
        .o_rdata (name_rd)
    );

    // Finished records waiting for the emitter.
    srp_rec_queue u_rec_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_pop          (desc_pop),
        .i_hash_rd_word (hash_word),
        .o_full         (q_full),
        .o_empty        (q_empty),
        .o_wslot        (wslot),
        .o_rslot        (rslot),
        .o_head         (head),
        .o_hash_rd      (hash_rd)
    );

    // Part emitter and output queue.
    srp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (head),
        .i_hash_data  (hash_rd),
        .i_name_data  (name_rd),
        .i_pop        (pop),
        .o_desc_pop   (desc_pop),
        .o_hash_word  (hash_word),
        .o_name_re    (name_re),
        .o_name_pos   (name_pos),
        .o_part       (part),
        .o_empty      (empty)
    );

    assign o_entry_slot  = part.entry_slot;
    assign o_part_kind   = part.part_kind;
    assign o_part_index  = part.part_index;
    assign o_part_data   = part.part_data;
    assign o_name_length = part.name_length;
    assign o_last_part   = part.last_part;

endmodule

>>> tb/srp_parser_checker.sv
// Checker for the shadow record parser: predicts the record parts each accepted file
// byte should produce and compares them, oldest first, with the parts that are popped.
// Depends on srp_pkg for sizes, characters and the part layout.

module srp_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_file,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [3:0]  i_entry_slot,
    input  logic        i_part_kind,
    input  logic [4:0]  i_part_index,
    input  logic [63:0] i_part_data,
    input  logic [4:0]  i_name_length,
    input  logic        i_last_part,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        LINE_BEGIN,
        LINE_NAME,
        LINE_HASH,
        LINE_SKIP,
        LINE_FULL
    } t_line_phase;

    // Shadow copy of the parser state.
    t_line_phase phase;
    logic [7:0]  name_bytes [srp_pkg::NAME_CAPACITY];
    int          name_used;
    bit          name_overflow;
    logic [63:0] hash_words [srp_pkg::HASH_WORDS];
    int          digit_count;
    logic [3:0]  high_digit;
    bit          digit_error;
    int          records;

    // Parts still owed by the block, oldest first.
    srp_pkg::t_part awaited_parts [$];
    int             bad_parts = 0;
    int             pending_count = 0;

    assign o_fail_count = bad_parts;
    assign o_pending    = pending_count;

    // Start a new file: the line, the hash digit count and the record count all clear.
    task automatic restart_file();
        phase         = LINE_BEGIN;
        name_used     = 0;
        name_overflow = 1'b0;
        digit_count   = 0;
        high_digit    = 4'd0;
        digit_error   = 1'b0;
        records       = 0;
    endtask

    // The colon has been seen; hex digits follow.
    task automatic open_hash();
        phase       = LINE_HASH;
        digit_count = 0;
        high_digit  = 4'd0;
        digit_error = 1'b0;
    endtask

    // Names keep at most NAME_CAPACITY-1 bytes; anything longer only marks the overflow.
    task automatic store_name_byte(input logic [7:0] b);
        if (name_used < srp_pkg::NAME_CAPACITY - 1) begin
            name_bytes[name_used] = b;
            name_used++;
        end else begin
            name_overflow = 1'b1;
        end
    endtask

    task automatic queue_part(input logic kind, input int idx, input logic [63:0] data,
                              input logic is_last);
        srp_pkg::t_part p;
        p.entry_slot  = srp_pkg::ENTRY_W'(records);
        p.part_kind   = kind;
        p.part_index  = srp_pkg::PART_IDX_W'(idx);
        p.part_data   = data;
        p.name_length = srp_pkg::NAME_LEN_W'(name_used);
        p.last_part   = is_last;
        awaited_parts.push_back(p);
    endtask

    // End of a line: a well-formed record yields its name bytes, then four hash words.
    task automatic close_line();
        int j;
        if (phase != LINE_FULL) begin
            if (phase == LINE_HASH && name_used >= 1 && !name_overflow &&
                digit_count == srp_pkg::HEX_DIGITS && !digit_error) begin
                for (j = 0; j < name_used; j++) begin
                    queue_part(srp_pkg::PART_NAME, j, 64'(name_bytes[j]), 1'b0);
                end
                for (j = 0; j < srp_pkg::HASH_WORDS; j++) begin
                    queue_part(srp_pkg::PART_HASH, j, hash_words[j],
                               j == srp_pkg::HASH_WORDS - 1);
                end
                records++;
            end
            phase = (records >= srp_pkg::MAX_ENTRIES) ? LINE_FULL : LINE_BEGIN;
        end
    endtask

    // Advance the shadow parser by one file byte.
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic [3:0] digit;
        int         w;
        if (phase != LINE_FULL) begin
            if (b == srp_pkg::CH_LF || b == srp_pkg::CH_CR) begin
                close_line();
            end else begin
                case (phase)
                    LINE_BEGIN: begin
                        name_used     = 0;
                        name_overflow = 1'b0;
                        if (b == srp_pkg::CH_COMMENT) begin
                            phase = LINE_SKIP;
                        end else if (b == srp_pkg::CH_COLON) begin
                            open_hash();
                        end else begin
                            phase = LINE_NAME;
                            store_name_byte(b);
                        end
                    end
                    LINE_NAME: begin
                        if (b == srp_pkg::CH_COLON) begin
                            open_hash();
                        end else begin
                            store_name_byte(b);
                        end
                    end
                    LINE_HASH: begin
                        if (digit_count >= srp_pkg::HEX_DIGITS) begin
                            // Too many characters: the count sticks one past a full hash.
                            digit_count = srp_pkg::HEX_DIGITS + 1;
                        end else begin
                            if (b >= "0" && b <= "9") begin
                                digit = 4'(b - "0");
                            end else if (b >= "a" && b <= "f") begin
                                digit = 4'(b - "a" + 8'd10);
                            end else if (b >= "A" && b <= "F") begin
                                digit = 4'(b - "A" + 8'd10);
                            end else begin
                                digit       = 4'd0;
                                digit_error = 1'b1;
                            end
                            // Digit pairs shift into the word they belong to, first pair on top.
                            if (digit_count % 2 == 0) begin
                                high_digit = digit;
                            end else begin
                                w = (digit_count >> 4) & (srp_pkg::HASH_WORDS - 1);
                                hash_words[w] = {hash_words[w][55:0], high_digit, digit};
                            end
                            digit_count++;
                        end
                    end
                    default: begin
                    end
                endcase
                if (eof) begin
                    close_line();
                end
            end
        end
        if (eof) begin
            restart_file();
        end
    endtask

    // Compare popped beats with the predictions, then predict from the pushed beat.
    always @(posedge i_clk) begin : watch_channels
        srp_pkg::t_part want;
        if (!i_rst_n) begin
            restart_file();
            awaited_parts.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (awaited_parts.size() == 0) begin
                    bad_parts++;
                    if (bad_parts <= MAX_REPORTS) begin
                        $display("%0t: unexpected part: slot %0d kind %0d index %0d",
                                 $time, i_entry_slot, i_part_kind, i_part_index);
                        $display("  data %h len %0d last %0d",
                                 i_part_data, i_name_length, i_last_part);
                    end
                end else begin
                    want = awaited_parts.pop_front();
                    if (want.entry_slot !== i_entry_slot || want.part_kind !== i_part_kind ||
                        want.part_index !== i_part_index || want.part_data !== i_part_data ||
                        want.name_length !== i_name_length ||
                        want.last_part !== i_last_part) begin
                        bad_parts++;
                        if (bad_parts <= MAX_REPORTS) begin
                            $display("%0t: part differs from prediction", $time);
                            $display({"  expected slot %0d kind %0d index %0d",
                                      " data %h len %0d last %0d"},
                                     want.entry_slot, want.part_kind, want.part_index,
                                     want.part_data, want.name_length, want.last_part);
                            $display({"  actual   slot %0d kind %0d index %0d",
                                      " data %h len %0d last %0d"},
                                     i_entry_slot, i_part_kind, i_part_index,
                                     i_part_data, i_name_length, i_last_part);
                        end
                    end
                end
            end
            if (i_push && !i_full) begin
                parse_byte(i_byte_value, i_end_of_file);
            end
        end
        pending_count = awaited_parts.size();
    end

endmodule

>>> tb/shadow_record_parser_tb.sv
// Testbench top of the shadow record parser: sends credential file bytes in bursts,
// pops record parts on a stall pattern, and gives the verdict.
// Depends on srp_pkg, shadow_record_parser and srp_parser_checker.

module shadow_record_parser_tb;

    typedef enum int {
        TERM_LF,
        TERM_CR,
        TERM_CRLF,
        TERM_NONE
    } t_line_end;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_RANDOM,
        POP_SPARSE,
        POP_LONG_STALL
    } t_pop_mode;

    localparam int    TAIL_CYCLES = 64;
    localparam string DIGIT_POOL  = "0123456789abcdefABCDEF";

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_byte_value;
    logic        i_end_of_file;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_entry_slot;
    logic        o_part_kind;
    logic [4:0]  o_part_index;
    logic [63:0] o_part_data;
    logic [4:0]  o_name_length;
    logic        o_last_part;

    int          fail_count;
    int          pending;
    logic [7:0]  line_buf [$];
    int          burst_left = 0;
    int          bytes_sent = 0;
    bit          draining = 1'b0;
    logic [15:0] pop_tick = '0;

    shadow_record_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_byte_value  (i_byte_value),
        .i_end_of_file (i_end_of_file),
        .empty         (empty),
        .pop           (pop),
        .o_entry_slot  (o_entry_slot),
        .o_part_kind   (o_part_kind),
        .o_part_index  (o_part_index),
        .o_part_data   (o_part_data),
        .o_name_length (o_name_length),
        .o_last_part   (o_last_part)
    );

    srp_parser_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_byte_value  (i_byte_value),
        .i_end_of_file (i_end_of_file),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_entry_slot  (o_entry_slot),
        .i_part_kind   (o_part_kind),
        .i_part_index  (o_part_index),
        .i_part_data   (o_part_data),
        .i_name_length (o_name_length),
        .i_last_part   (o_last_part),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: the stall pattern follows bits 8:7 of pop_tick; everything drains at the end.
    always @(posedge i_clk) begin
        pop_tick <= pop_tick + 16'd1;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (draining) begin
            pop <= 1'b1;
        end else begin
            case (t_pop_mode'(pop_tick[8:7]))
                POP_ALWAYS: pop <= 1'b1;
                POP_RANDOM: pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= (pop_tick[1:0] == 2'd0);
                default:    pop <= (pop_tick[5:4] == 2'd0);
            endcase
        end
    end

    // One file byte as one beat; bursts of random length with random gaps between them.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        push          <= 1'b1;
        i_byte_value  <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            line_buf.push_back(s[k]);
        end
    endtask

    task automatic put_repeat(input logic [7:0] ch, input int n);
        repeat (n) line_buf.push_back(ch);
    endtask

    // Random name bytes: no terminator, no colon, and no comment mark in front.
    task automatic put_name(input int n);
        logic [7:0] b;
        int         k;
        for (k = 0; k < n; k++) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == srp_pkg::CH_LF || b == srp_pkg::CH_CR || b == srp_pkg::CH_COLON ||
                       (k == 0 && b == srp_pkg::CH_COMMENT));
            line_buf.push_back(b);
        end
    endtask

    // Random hex digits in mixed case.
    task automatic put_hex(input int n);
        repeat (n) line_buf.push_back(DIGIT_POOL[$urandom_range(0, DIGIT_POOL.len() - 1)]);
    endtask

    // Send the buffered line with its terminator; the end-of-file mark rides on the last byte.
    task automatic send_line(input t_line_end term, input bit eof);
        int k;
        if (term == TERM_NONE && line_buf.size() == 0) begin
            term = TERM_LF;
        end
        case (term)
            TERM_LF: line_buf.push_back(srp_pkg::CH_LF);
            TERM_CR: line_buf.push_back(srp_pkg::CH_CR);
            TERM_CRLF: begin
                line_buf.push_back(srp_pkg::CH_CR);
                line_buf.push_back(srp_pkg::CH_LF);
            end
            default: begin
            end
        endcase
        for (k = 0; k < line_buf.size(); k++) begin
            send_byte(line_buf[k], eof && k == line_buf.size() - 1);
        end
        line_buf.delete();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_byte_value  <= 8'd0;
        i_end_of_file <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Skipped lines: a comment, an empty line ended by CR LF, a line with no colon.
        put_text("#x");
        send_line(TERM_LF, 1'b0);
        send_line(TERM_CRLF, 1'b0);
        put_text("ab");
        send_line(TERM_CR, 1'b0);

        // The longest name that is kept, with an all-ones hash in upper case.
        put_name(srp_pkg::NAME_CAPACITY - 1);
        put_text(":");
        put_repeat("F", srp_pkg::HEX_DIGITS);
        send_line(TERM_CRLF, 1'b0);

        // Rejected lines: empty name, name one byte too long, lone star, bad digit.
        put_text(":");
        put_hex(srp_pkg::HEX_DIGITS);
        send_line(TERM_LF, 1'b0);
        put_name(srp_pkg::NAME_CAPACITY);
        put_text(":");
        put_hex(srp_pkg::HEX_DIGITS);
        send_line(TERM_LF, 1'b0);
        put_text("u:*");
        send_line(TERM_LF, 1'b0);
        put_name(1);
        put_text(":");
        put_hex(30);
        put_text("g");
        put_hex(33);
        send_line(TERM_LF, 1'b0);

        // A hash one digit too long; the end-of-file mark rides on its terminator.
        put_name(1);
        put_text(":");
        put_hex(srp_pkg::HEX_DIGITS + 1);
        send_line(TERM_LF, 1'b1);

        // A new file whose only record is closed by the end-of-file mark alone.
        put_name(1);
        put_text(":");
        put_hex(srp_pkg::HEX_DIGITS);
        send_line(TERM_NONE, 1'b1);
        push <= 1'b0;

        // Wait for every predicted part, then give stray parts a chance to show up.
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("shadow_record_parser: match");
        end else begin
            $display("shadow_record_parser: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("shadow_record_parser: mismatch");
        $finish;
    end

endmodule

>>> shadow_record_parser.f
hdl/srp_pkg.sv
hdl/srp_ram.sv
hdl/srp_front.sv
hdl/srp_rec_queue.sv
hdl/srp_back.sv
hdl/shadow_record_parser.sv
tb/srp_parser_checker.sv
tb/shadow_record_parser_tb.sv
